@@ hw/rtl/ckre_pkg.sv @@
// ============================================================================
// ckre_pkg - shared types and constants for the color key run extractor
// Register indexes, dimension limits, key band constants and helpers.
// ============================================================================
`default_nettype none

package ckre_pkg;

    // Largest image dimension; the output field widths follow from it.
    localparam int DIM_W      = 12;
    localparam int DIM_CNT_W  = DIM_W + 1;
    localparam logic [DIM_CNT_W-1:0] MAX_DIMENSION = 13'd4096;

    // Register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_INVERTED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd3;

    // Register reset values
    localparam logic [23:0]          KEY_COLOR_RST = 24'h00FF00;
    localparam logic [DIM_CNT_W-1:0] DIM_RST       = 13'd4096;

    // Key band constants
    localparam logic [23:0] KEY_WHITE  = 24'hFFFFFF;
    localparam logic [23:0] KEY_BLACK  = 24'h000000;
    localparam logic [7:0]  WHITE_LO   = 8'hEF;
    localparam logic [7:0]  BLACK_HI   = 8'h10;
    localparam logic [7:0]  BAND_HALF  = 8'h11;
    localparam logic [7:0]  CHAN_MAX   = 8'hFF;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
    } band_t;

    // A zero or oversized dimension means the maximum.
    function automatic logic [DIM_CNT_W-1:0] eff_dim(input logic [DIM_CNT_W-1:0] v);
        logic [DIM_CNT_W-1:0] res;
        if (v == '0 || v > MAX_DIMENSION)
            res = MAX_DIMENSION;
        else
            res = v;
        return res;
    endfunction

    // Per-channel bounds for one key byte.
    function automatic band_t chan_band(input logic [23:0] key_color,
                                        input logic [7:0]  key);
        band_t      b;
        logic [8:0] sum;
        sum = {1'b0, key} + {1'b0, BAND_HALF};
        if (key_color == KEY_WHITE) begin
            b.lo = WHITE_LO;
            b.hi = CHAN_MAX;
        end else if (key_color == KEY_BLACK) begin
            b.lo = '0;
            b.hi = BLACK_HI;
        end else begin
            b.lo = (key >= BAND_HALF) ? key - BAND_HALF : '0;
            b.hi = sum[8] ? CHAN_MAX : sum[7:0];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/color_key_run_extractor_top.sv @@
// ============================================================================
// color_key_run_extractor_top - color key horizontal run extractor
// Classifies raster-order RGB pixels against a key color band and emits one
// (start, end, row) transaction each time a run of wanted pixels closes.
// ============================================================================
// Usage:
//   s_* channel: one pixel per transaction in raster order (red, green, blue).
//   m_* channel: one run per transaction; run_end is exclusive.
//   cfg_*: register writes (key color, inverted match, width, height); write
//     only while the block is idle. Writes never reset counters or open runs.
// Pipeline: a pixel is held in the input register and classified on its way
//   into the output register, from which a run that the pixel closes is
//   offered on m_*.
// Throughput: one pixel per cycle sustained while m_tready stays high. The
//   only loop is the run state update (column, row, open flag, begin column).
// Reset: counters clear to row 0 column 0, no run open, both pipeline
//   registers empty; registers return to key 0x00FF00, normal match,
//   4096 x 4096.
// Stall: while a run waits in the output register with m_tready low, the
//   held pixel does not advance, whether it closes a run or not; the input
//   register holds one pixel and s_tready drops. No pixel or run is lost.
// ============================================================================
`default_nettype none

module color_key_run_extractor_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [ckre_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ckre_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    // Run output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // run_start [11:0], run_end [24:12],
                                        // run_row [36:25], zero [39:37]
);

    localparam int DW = ckre_pkg::DIM_W;
    localparam int CW = ckre_pkg::DIM_CNT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [23:0]   key_color_reg;
    logic          match_inv_reg;
    logic [CW-1:0] width_reg;
    logic [CW-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_color_reg <= ckre_pkg::KEY_COLOR_RST;
            match_inv_reg <= 1'b0;
            width_reg     <= ckre_pkg::DIM_RST;
            height_reg    <= ckre_pkg::DIM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ckre_pkg::REG_KEY_COLOR:      key_color_reg <= cfg_data[23:0];
                ckre_pkg::REG_MATCH_INVERTED: match_inv_reg <= cfg_data[0];
                ckre_pkg::REG_IMAGE_WIDTH:    width_reg     <= cfg_data[CW-1:0];
                ckre_pkg::REG_IMAGE_HEIGHT:   height_reg    <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Bounds depend only on configuration, which is static while pixels flow.
    ckre_pkg::band_t band_r, band_g, band_b;
    logic [CW-1:0]   eff_w, eff_h;

    always_comb
    begin
        band_r = ckre_pkg::chan_band(key_color_reg, key_color_reg[7:0]);
        band_g = ckre_pkg::chan_band(key_color_reg, key_color_reg[15:8]);
        band_b = ckre_pkg::chan_band(key_color_reg, key_color_reg[23:16]);
        eff_w  = ckre_pkg::eff_dim(width_reg);
        eff_h  = ckre_pkg::eff_dim(height_reg);
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        pix_valid_reg, pix_valid_next;
    logic [23:0] pix_reg;
    logic        out_valid_reg, out_valid_next;
    logic        proc_go;
    logic        in_fire;

    // Advance the pixel when the output register is free or being drained.
    assign proc_go  = pix_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !pix_valid_reg || proc_go;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        if (in_fire)
            pix_valid_next = 1'b1;
        else if (proc_go)
            pix_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            pix_reg <= s_tdata;
    end

    // ------------------------------------------------------------------
    // Classification and run state
    // ------------------------------------------------------------------
    logic [DW-1:0] col_reg, col_next;
    logic [DW-1:0] row_reg, row_next;
    logic          run_open_reg, run_open_next;
    logic [DW-1:0] run_begin_reg, run_begin_next;

    logic          match, wanted, row_end, emit;
    logic [CW-1:0] col_p1, row_p1;
    logic [DW-1:0] begin_eff;
    logic [DW-1:0] res_start;
    logic [CW-1:0] res_end;

    always_comb
    begin
        match = (pix_reg[7:0]   >= band_r.lo) && (pix_reg[7:0]   <= band_r.hi) &&
                (pix_reg[15:8]  >= band_g.lo) && (pix_reg[15:8]  <= band_g.hi) &&
                (pix_reg[23:16] >= band_b.lo) && (pix_reg[23:16] <= band_b.hi);
        wanted    = match ^ match_inv_reg;
        col_p1    = {1'b0, col_reg} + CW'(1);
        row_p1    = {1'b0, row_reg} + CW'(1);
        row_end   = (col_p1 >= eff_w);
        begin_eff = run_open_reg ? run_begin_reg : col_reg;

        // A wanted pixel closes its run only at row end; an unwanted one
        // closes whatever run is open, ending before itself.
        if (wanted)
        begin
            emit      = row_end;
            res_start = begin_eff;
            res_end   = col_p1;
        end
        else
        begin
            emit      = run_open_reg;
            res_start = run_begin_reg;
            res_end   = {1'b0, col_reg};
        end
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        run_open_next  = run_open_reg;
        run_begin_next = run_begin_reg;
        if (proc_go)
        begin
            run_open_next  = wanted && !row_end;
            run_begin_next = begin_eff;
            if (row_end)
            begin
                col_next = '0;
                row_next = (row_p1 >= eff_h) ? '0 : row_p1[DW-1:0];
            end
            else
            begin
                col_next = col_p1[DW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [DW-1:0] out_start_reg;
    logic [CW-1:0] out_end_reg;
    logic [DW-1:0] out_row_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_go)
            out_valid_next = emit;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            run_open_reg  <= 1'b0;
            run_begin_reg <= '0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            run_open_reg  <= run_open_next;
            run_begin_reg <= run_begin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && emit)
        begin
            out_start_reg <= res_start;
            out_end_reg   <= res_end;
            out_row_reg   <= row_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_row_reg, out_end_reg, out_start_reg};

`ifndef SYNTHESIS
    // An open run always began at or before the current column.
    a_begin_le_col: assert property (@(posedge clk) disable iff (!rst_n)
        run_open_reg |-> (run_begin_reg <= col_reg))
        else $error("open run begins past the current column");

    // Every emitted run is non-empty.
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_end_reg > {1'b0, out_start_reg}))
        else $error("emitted run is empty");

    // A held pixel stays put until the output side frees up.
    a_pix_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid_reg && !proc_go) |=> (pix_valid_reg && $stable(pix_reg)))
        else $error("pending pixel lost or changed");

    // A pixel that reaches row end always leaves the run closed.
    a_row_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && row_end) |=> (!run_open_reg && col_reg == '0))
        else $error("row end did not close the run");
`endif

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ============================================================================
// tb - self-checking testbench for color_key_run_extractor_top
// Streams RGB pixels through the block under random source gaps and sink
// stalls, predicts every horizontal run from a cycle-free model of the key
// bands and the column/row/run state, and compares each run transaction
// field by field. A directed opening covers band edges, the white and black
// keys, saturation, inverted match, out-of-range dimensions and dimensions
// lowered mid-row and mid-frame; random phases with fresh settings follow.
// ============================================================================
module tb;

    // One run transaction as it sits on m_tdata, lowest field last.
    typedef struct packed {
        logic [2:0]  pad;
        logic [11:0] run_row;
        logic [12:0] run_end;
        logic [11:0] run_start;
    } run_t;

    // ------------------------------------------------------------------------
    // Run scoreboard: keeps its own copy of the registers and the raster
    // state, turns each accepted pixel into the run it closes (if any) and
    // holds those runs until the block delivers them.
    // ------------------------------------------------------------------------
    class run_scoreboard;
        logic [23:0] key_color;
        logic        match_inverted;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [11:0] column;
        logic [11:0] row;
        logic        run_open;
        logic [11:0] run_first;
        run_t        runs_due[$];
        int          errors;

        function new();
            key_color      = ckre_pkg::KEY_COLOR_RST;
            match_inverted = 1'b0;
            image_width    = ckre_pkg::DIM_RST;
            image_height   = ckre_pkg::DIM_RST;
            column         = '0;
            row            = '0;
            run_open       = 1'b0;
            run_first      = '0;
            errors         = 0;
        endfunction

        function int pending();
            return runs_due.size();
        endfunction

        function void write_reg(logic [ckre_pkg::CFG_IDX_W-1:0]  idx,
                                logic [ckre_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ckre_pkg::REG_KEY_COLOR:      key_color      = data[23:0];
                ckre_pkg::REG_MATCH_INVERTED: match_inverted = data[0];
                ckre_pkg::REG_IMAGE_WIDTH:    image_width    = data[12:0];
                ckre_pkg::REG_IMAGE_HEIGHT:   image_height   = data[12:0];
                default: ;
            endcase
        endfunction

        function logic [12:0] clamp_dim(logic [12:0] v);
            return (v == '0 || v > ckre_pkg::MAX_DIMENSION) ? ckre_pkg::MAX_DIMENSION : v;
        endfunction

        // Bounds of one channel for the current key.
        function void band(input logic [7:0] key, output logic [7:0] lo,
                           output logic [7:0] hi);
            if (key_color == ckre_pkg::KEY_WHITE) begin
                lo = 8'hEF;
                hi = 8'hFF;
            end else if (key_color == ckre_pkg::KEY_BLACK) begin
                lo = 8'h00;
                hi = 8'h10;
            end else begin
                lo = (key >= ckre_pkg::BAND_HALF) ? key - ckre_pkg::BAND_HALF : 8'h00;
                hi = ({1'b0, key} + {1'b0, ckre_pkg::BAND_HALF} > 9'h0FF) ?
                     8'hFF : key + ckre_pkg::BAND_HALF;
            end
        endfunction

        function logic in_band(logic [7:0] key, logic [7:0] pix);
            logic [7:0] lo;
            logic [7:0] hi;
            band(key, lo, hi);
            return pix >= lo && pix <= hi;
        endfunction

        function void note_pixel(logic [23:0] pix);
            logic [12:0] w;
            logic [12:0] h;
            logic        wanted;
            logic        row_end;
            run_t        run;
            w = clamp_dim(image_width);
            h = clamp_dim(image_height);
            wanted = (in_band(key_color[7:0], pix[7:0]) &&
                      in_band(key_color[15:8], pix[15:8]) &&
                      in_band(key_color[23:16], pix[23:16])) ^ match_inverted;
            row_end = ({1'b0, column} + 13'd1) >= w;
            run.pad     = '0;
            run.run_row = row;
            if (wanted) begin
                if (!run_open) begin
                    run_open  = 1'b1;
                    run_first = column;
                end
                if (row_end) begin
                    run.run_start = run_first;
                    run.run_end   = {1'b0, column} + 13'd1;
                    runs_due.push_back(run);
                    run_open = 1'b0;
                end
            end else if (run_open) begin
                run.run_start = run_first;
                run.run_end   = {1'b0, column};
                runs_due.push_back(run);
                run_open = 1'b0;
            end
            if (row_end) begin
                column   = '0;
                run_open = 1'b0;
                row      = (({1'b0, row} + 13'd1) >= h) ? 12'd0 : row + 12'd1;
            end else begin
                column = column + 12'd1;
            end
        endfunction

        function void check_run(run_t got);
            run_t want;
            if (runs_due.size() == 0) begin
                $error("run transaction with none expected: start %0d end %0d row %0d",
                       got.run_start, got.run_end, got.run_row);
                errors++;
                return;
            end
            want = runs_due.pop_front();
            if (got.run_start != want.run_start) begin
                $error("run_start: expected %0d, got %0d", want.run_start, got.run_start);
                errors++;
            end
            if (got.run_end != want.run_end) begin
                $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
                errors++;
            end
            if (got.run_row != want.run_row) begin
                $error("run_row: expected %0d, got %0d", want.run_row, got.run_row);
                errors++;
            end
            if (got.pad != want.pad) begin
                $error("pad: expected %0d, got %0d", want.pad, got.pad);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [ckre_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ckre_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [23:0]                     s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [39:0]                     m_tdata;

    run_scoreboard sb;
    bit            quiet      = 1'b0;   // no gaps and no stalls while set
    bit            aim_match  = 1'b1;   // class of the pixels being generated
    int            hold_left  = 0;
    int            ready_sel;
    int            idle_cycles = 0;

    color_key_run_extractor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sink: hold m_tready in stretches, mostly ready, sometimes a short stall,
    // now and then a long one. Drive at the falling edge.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (quiet) begin
            m_tready  = 1'b1;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
        end else begin
            ready_sel = $urandom_range(0, 99);
            if (ready_sel < 70) begin
                m_tready  = 1'b1;
                hold_left = $urandom_range(0, 8);
            end else if (ready_sel < 95) begin
                m_tready  = 1'b0;
                hold_left = $urandom_range(0, 3);
            end else begin
                m_tready  = 1'b0;
                hold_left = $urandom_range(10, 40);
            end
        end
    end

    // Check every run transaction at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && sb != null && m_tvalid && m_tready)
            sb.check_run(run_t'(m_tdata));
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 3000) begin
            $display("color_key_run_extractor_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------
    function automatic int sender_gap();
        int sel;
        if (quiet)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one pixel, possibly after a gap, and record it once accepted.
    task automatic send_pixel(input logic [23:0] pix);
        int gap;
        @(negedge clk);
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = pix;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_pixel(pix);
    endtask

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        send_pixel({b, g, r});
    endtask

    // Drop valid, wait for every pending run, then let the pipeline empty.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ckre_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [ckre_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    // One channel value either inside the band of its key byte or outside it,
    // leaning on the band edges and the values just past them.
    function automatic logic [7:0] pick_channel(logic [7:0] key, bit inside_band);
        logic [7:0] lo;
        logic [7:0] hi;
        int         sel;
        bit         below;
        sb.band(key, lo, hi);
        sel = $urandom_range(0, 7);
        if (inside_band) begin
            if (sel == 0)
                return lo;
            if (sel == 1)
                return hi;
            return 8'($urandom_range(int'(lo), int'(hi)));
        end
        below = (hi == 8'hFF) || (lo != 8'h00 && sel[0]);
        if (below)
            return (sel < 3) ? lo - 8'd1 : 8'($urandom_range(0, int'(lo) - 1));
        return (sel < 3) ? hi + 8'd1 : 8'($urandom_range(int'(hi) + 1, 255));
    endfunction

    // Runs of pixels of one class with random length; a little pure noise.
    function automatic logic [23:0] make_pixel();
        logic [23:0] pix;
        int          sel;
        int          odd;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return 24'($urandom);
        if (sel < 30)
            aim_match = !aim_match;
        odd = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
            if (aim_match)
                pix[8*i +: 8] = pick_channel(sb.key_color[8*i +: 8], 1'b1);
            else if (i == odd)
                pix[8*i +: 8] = pick_channel(sb.key_color[8*i +: 8], 1'b0);
            else if ($urandom_range(0, 1) == 1)
                pix[8*i +: 8] = pick_channel(sb.key_color[8*i +: 8], 1'b1);
            else
                pix[8*i +: 8] = 8'($urandom);
        end
        return pix;
    endfunction

    // Dimension write with junk above the 13 bits the register keeps.
    function automatic logic [ckre_pkg::CFG_DATA_W-1:0] dim_word(logic [12:0] v);
        logic [10:0] junk;
        junk = 11'($urandom);
        return {junk, v};
    endfunction

    function automatic logic [7:0] corner_byte();
        case ($urandom_range(0, 10))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h10;
            3:       return 8'h11;
            4:       return 8'h12;
            5:       return 8'h80;
            6:       return 8'hED;
            7:       return 8'hEE;
            8:       return 8'hEF;
            9:       return 8'hFE;
            default: return 8'hFF;
        endcase
    endfunction

    // New settings for a random phase; each register is rewritten at random.
    task automatic shuffle_config(input bit all);
        logic [23:0] key;
        logic [12:0] dim;
        if (all || $urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 5))
                0:       key = ckre_pkg::KEY_WHITE;
                1:       key = ckre_pkg::KEY_BLACK;
                2:       key = {corner_byte(), corner_byte(), corner_byte()};
                5:       key = ckre_pkg::KEY_COLOR_RST;
                default: key = 24'($urandom);
            endcase
            write_reg(ckre_pkg::REG_KEY_COLOR, key);
        end
        if (all || $urandom_range(0, 1) == 1)
            write_reg(ckre_pkg::REG_MATCH_INVERTED, 24'($urandom));
        if (all || $urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 11))
                7:       dim = 13'd1;
                8:       dim = 13'd0;
                9:       dim = ckre_pkg::MAX_DIMENSION;
                10:      dim = 13'($urandom_range(4097, 8191));
                11:      dim = 13'($urandom_range(13, 300));
                default: dim = 13'($urandom_range(1, 12));
            endcase
            write_reg(ckre_pkg::REG_IMAGE_WIDTH, dim_word(dim));
        end
        if (all || $urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
                6:       dim = 13'd1;
                7:       dim = 13'd0;
                8:       dim = ckre_pkg::MAX_DIMENSION;
                9:       dim = 13'($urandom_range(4097, 8191));
                default: dim = 13'($urandom_range(1, 4));
            endcase
            write_reg(ckre_pkg::REG_IMAGE_HEIGHT, dim_word(dim));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        int random_pixels;
        bit first;

        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, green key: band edges, a run closed by a pixel of
        // the other class, then a run left open.
        send_rgb(8'h00, 8'hFF, 8'h00);
        send_rgb(8'h11, 8'hEE, 8'h11);
        send_rgb(8'h12, 8'hEE, 8'h11);
        send_rgb(8'h00, 8'hED, 8'h00);
        send_rgb(8'hFF, 8'hFF, 8'hFF);
        send_rgb(8'h00, 8'hFF, 8'h00);
        settle();

        // Width lowered below the current column: the next pixel ends the row.
        write_reg(ckre_pkg::REG_IMAGE_WIDTH, 24'd3);
        send_rgb(8'h00, 8'hFF, 8'h00);
        settle();

        // White key, short rows and a two-row frame that wraps.
        write_reg(ckre_pkg::REG_KEY_COLOR, ckre_pkg::KEY_WHITE);
        write_reg(ckre_pkg::REG_IMAGE_WIDTH, 24'd2);
        write_reg(ckre_pkg::REG_IMAGE_HEIGHT, 24'd2);
        send_rgb(8'hEF, 8'hEF, 8'hEF);
        send_rgb(8'hFF, 8'hFF, 8'hFF);
        send_rgb(8'hEE, 8'hFF, 8'hFF);
        send_rgb(8'hFF, 8'hFF, 8'hFF);
        settle();

        // Black key, inverted match (junk in the upper bits), one-pixel rows.
        write_reg(ckre_pkg::REG_KEY_COLOR, ckre_pkg::KEY_BLACK);
        write_reg(ckre_pkg::REG_MATCH_INVERTED, 24'hFFFFFF);
        write_reg(ckre_pkg::REG_IMAGE_WIDTH, 24'd1);
        send_rgb(8'h10, 8'h10, 8'h10);
        send_rgb(8'h11, 8'h00, 8'h00);
        send_rgb(8'h00, 8'h00, 8'h00);
        send_rgb(8'h80, 8'h7F, 8'hC3);
        settle();

        // Bands saturated at both ends; zero and oversized dimensions.
        write_reg(ckre_pkg::REG_KEY_COLOR, 24'hF80580);
        write_reg(ckre_pkg::REG_MATCH_INVERTED, 24'hFFFFFE);
        write_reg(ckre_pkg::REG_IMAGE_WIDTH, 24'hFFFFFF);
        write_reg(ckre_pkg::REG_IMAGE_HEIGHT, 24'd0);
        send_rgb(8'h6F, 8'h00, 8'hFF);
        send_rgb(8'h91, 8'h16, 8'hE7);
        send_rgb(8'h92, 8'h16, 8'hE7);
        settle();

        // Height lowered below the current row: wrap at the next row end.
        write_reg(ckre_pkg::REG_IMAGE_WIDTH, 24'd2);
        repeat (4) send_pixel(make_pixel());
        settle();
        write_reg(ckre_pkg::REG_IMAGE_HEIGHT, 24'd1);
        repeat (2) send_pixel(make_pixel());

        // Random phases, each with fresh settings.
        random_pixels = 0;
        first         = 1'b1;
        while (random_pixels < 720) begin
            settle();
            shuffle_config(first);
            first = 1'b0;
            quiet = ($urandom_range(0, 4) == 0);
            n     = $urandom_range(5, 60);
            repeat (n) send_pixel(make_pixel());
            random_pixels += n;
        end

        // Drain: wait for every run still due, then a few more cycles.
        @(negedge clk);
        s_tvalid = 1'b0;
        quiet    = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("color_key_run_extractor_top: match");
        else
            $display("color_key_run_extractor_top: mismatch");
        $finish;
    end

endmodule
